// ===== src/pts_pkg.sv =====
package pts_pkg;

    // Default table size
    localparam int SLOTS_DEF = 64;

    // Input kind codes
    localparam logic [2:0] KIND_READY    = 3'd0;
    localparam logic [2:0] KIND_UNREADY  = 3'd1;
    localparam logic [2:0] KIND_DISPATCH = 3'd2;
    localparam logic [2:0] KIND_RUN_DONE = 3'd3;
    localparam logic [2:0] KIND_PAUSE    = 3'd4;
    localparam logic [2:0] KIND_CLEAR    = 3'd5;

    // Outcome codes
    localparam logic [1:0] OUT_OK     = 2'd0;
    localparam logic [1:0] OUT_PAUSED = 2'd1;
    localparam logic [1:0] OUT_EMPTY  = 2'd2;

    // Policy codes
    localparam logic [1:0] POL_RR     = 2'd0;
    localparam logic [1:0] POL_FEWEST = 2'd1;
    localparam logic [1:0] POL_OLDEST = 2'd2;

    // Configuration register indexes
    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_WEIGHT = 1'b1;

    localparam logic [1:0]  POLICY_RST = 2'd0;
    localparam logic [3:0]  WEIGHT_RST = 4'd5;
    localparam logic [3:0]  WEIGHT_MAX = 4'd10;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

    // Weighted sum width: ten times a 32-bit value
    localparam int ACC_W     = 36;
    // Shift-and-add steps of the divide by ten, correction included
    localparam int DIV_STEPS = 7;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        OP_READY,
        OP_UNREADY,
        OP_DISPATCH,
        OP_RUN_DONE,
        OP_PAUSE,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        STAT_IDLE,
        STAT_READY,
        STAT_RUNNING
    } t_status;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SCAN,
        BK_PICK,
        BK_DECIDE,
        BK_CNT_WR,
        BK_MUL,
        BK_DIV,
        BK_MEAN_WR,
        BK_OUT
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [5:0]  slot;
        logic [31:0] now;
        logic [31:0] pause_end;
    } t_item;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [5:0]  chosen;
        logic [31:0] mean;
    } t_result;

endpackage

// ===== src/pts_front.sv =====
module pts_front
    import pts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [IN_DATA_W-1:0] i_tdata,
    input  logic [2:0]           i_tuser,
    output t_item                o_item,
    output logic                 o_item_valid,
    input  logic                 i_pop
);

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_slot_ok;
    logic       w_push;

    // Classify the incoming beat; out-of-range slots turn ready, not-ready and clear events into no-ops
    always_comb begin
        w_slot_ok      = int'(i_tdata[5:0]) < SLOTS;
        w_item.slot    = i_tdata[5:0];
        w_item.now     = i_tdata[37:6];
        w_item.pause_end = i_tdata[69:38];
        case (i_tuser)
            KIND_READY:    w_item.op = w_slot_ok ? OP_READY : OP_NOP;
            KIND_UNREADY:  w_item.op = w_slot_ok ? OP_UNREADY : OP_NOP;
            KIND_DISPATCH: w_item.op = OP_DISPATCH;
            KIND_RUN_DONE: w_item.op = OP_RUN_DONE;
            KIND_PAUSE:    w_item.op = OP_PAUSE;
            KIND_CLEAR:    w_item.op = w_slot_ok ? OP_CLEAR : OP_NOP;
            default:       w_item.op = OP_NOP;
        endcase
    end

    assign o_tready     = (r_cnt != 2'd2);
    assign w_push       = i_tvalid && o_tready;
    assign o_item       = r_q[r_rp];
    assign o_item_valid = (r_cnt != 2'd0);

    // Two-entry queue toward the executor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

// ===== src/pts_back.sv =====
module pts_back
    import pts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  logic       i_item_valid,
    output logic       o_pop,
    input  logic [1:0] i_policy,
    input  logic [3:0] i_weight,
    output t_result    o_res,
    output logic       o_res_valid,
    input  logic       i_res_ready
);

    localparam int SW = $clog2(SLOTS);
    localparam int KW = SW + 1;

    t_state  r_state, n_state;
    t_status r_status [SLOTS];
    logic [SLOTS-1:0] r_vstamp, r_vcount, r_vmean;

    logic [31:0] mem_stamp [SLOTS];
    logic [31:0] mem_count [SLOTS];
    logic [31:0] mem_mean  [SLOTS];

    logic [SW-1:0] rd_addr, wr_addr;
    logic          we_stamp, we_count, we_mean;
    logic [31:0]   wd_stamp, wd_count, wd_mean;
    logic [31:0]   r_stamp_q, r_count_q, r_mean_q;
    logic          r_vs_q, r_vc_q, r_vm_q;
    logic [31:0]   stamp_rd, count_rd, mean_rd;

    logic [31:0]      r_pause, r_tick, r_now;
    logic [SW-1:0]    r_last, r_base, r_best, r_cand_idx;
    logic [KW-1:0]    r_k;
    logic             r_cand_ok, r_cand_v, r_found;
    logic [31:0]      r_best_key;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_quo;
    logic [2:0]       r_div_cnt;
    t_result          r_res, r_out;
    logic             r_out_valid;

    logic [KW-1:0]    scan_sum;
    logic [SW-1:0]    scan_idx;
    logic             scan_last;
    logic             is_rr;
    logic [31:0]      cand_key;
    logic             take;
    logic [SW-1:0]    slot_idx;
    logic             paused;
    logic             out_free;
    logic [3:0]       w_clamp, w_inv;
    logic [31:0]      run_len;
    logic [ACC_W-1:0] prod_old, prod_new;
    logic [ACC_W-1:0] quo_n;
    logic [ACC_W-1:0] div_rem;

    assign stamp_rd = r_vs_q ? r_stamp_q : '0;
    assign count_rd = r_vc_q ? r_count_q : '0;
    assign mean_rd  = r_vm_q ? r_mean_q  : '0;

    // Scan address walks from the base slot and wraps
    assign scan_sum  = {1'b0, r_base} + r_k;
    assign scan_idx  = (scan_sum >= KW'(SLOTS)) ? SW'(scan_sum - KW'(SLOTS)) : SW'(scan_sum);
    assign scan_last = (r_k == KW'(SLOTS - 1));

    assign is_rr    = (i_policy != POL_FEWEST) && (i_policy != POL_OLDEST);
    assign cand_key = (i_policy == POL_FEWEST) ? count_rd : stamp_rd;
    assign take     = r_cand_v && r_cand_ok
                      && (!r_found || (!is_rr && (cand_key < r_best_key)));

    assign slot_idx = SW'(i_item.slot);
    assign paused   = (i_item.now < r_pause);
    assign out_free = !r_out_valid || i_res_ready;

    // Weighted mean terms
    assign w_clamp  = (i_weight > WEIGHT_MAX) ? WEIGHT_MAX : i_weight;
    assign w_inv    = WEIGHT_MAX - w_clamp;
    assign run_len  = r_now - r_tick;
    assign prod_old = ACC_W'(mean_rd) * ACC_W'(w_inv);
    assign prod_new = ACC_W'(run_len) * ACC_W'(w_clamp);

    // Divide by ten: approach 0.8x / 8 by shifts and adds, then fix by one
    assign div_rem = r_acc - ((r_quo << 3) + (r_quo << 1));

    always_comb begin
        case (r_div_cnt)
            3'd0:    quo_n = (r_acc >> 1) + (r_acc >> 2);
            3'd1:    quo_n = r_quo + (r_quo >> 4);
            3'd2:    quo_n = r_quo + (r_quo >> 8);
            3'd3:    quo_n = r_quo + (r_quo >> 16);
            3'd4:    quo_n = r_quo + (r_quo >> 32);
            3'd5:    quo_n = r_quo >> 3;
            3'd6:    quo_n = (div_rem > ACC_W'(9)) ? r_quo + ACC_W'(1) : r_quo;
            default: quo_n = r_quo;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_item_valid) begin
                    case (i_item.op)
                        OP_DISPATCH: n_state = paused ? BK_OUT : BK_SCAN;
                        OP_RUN_DONE: n_state = BK_MUL;
                        default:     n_state = BK_OUT;
                    endcase
                end
            end
            BK_SCAN:    n_state = scan_last ? BK_PICK : BK_SCAN;
            BK_PICK:    n_state = BK_DECIDE;
            BK_DECIDE:  n_state = r_found ? BK_CNT_WR : BK_OUT;
            BK_CNT_WR:  n_state = BK_OUT;
            BK_MUL:     n_state = BK_DIV;
            BK_DIV:     n_state = (r_div_cnt == 3'(DIV_STEPS - 1)) ? BK_MEAN_WR : BK_DIV;
            BK_MEAN_WR: n_state = BK_OUT;
            BK_OUT:     n_state = out_free ? BK_IDLE : BK_OUT;
            default:    n_state = BK_IDLE;
        endcase
    end

    // Memory controls and queue pop
    always_comb begin
        o_pop    = 1'b0;
        rd_addr  = r_last;
        wr_addr  = slot_idx;
        we_stamp = 1'b0;
        we_count = 1'b0;
        we_mean  = 1'b0;
        wd_stamp = '0;
        wd_count = '0;
        wd_mean  = '0;
        case (r_state)
            BK_IDLE: begin
                o_pop = i_item_valid;
                if (i_item_valid) begin
                    case (i_item.op)
                        OP_READY: begin
                            we_stamp = (r_status[slot_idx] == STAT_IDLE);
                            wd_stamp = i_item.now;
                        end
                        OP_CLEAR: begin
                            we_stamp = 1'b1;
                            we_count = 1'b1;
                            we_mean  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            BK_SCAN:   rd_addr = scan_idx;
            BK_DECIDE: rd_addr = r_best;
            BK_CNT_WR: begin
                wr_addr  = r_best;
                we_count = 1'b1;
                wd_count = (count_rd == COUNT_MAX) ? count_rd : count_rd + 32'd1;
            end
            BK_MEAN_WR: begin
                wr_addr = r_last;
                we_mean = 1'b1;
                wd_mean = r_quo[31:0];
            end
            default: ;
        endcase
    end

    // Slot memories with registered reads
    always_ff @(posedge i_clk) begin
        if (we_stamp) begin
            mem_stamp[wr_addr] <= wd_stamp;
        end
        if (we_count) begin
            mem_count[wr_addr] <= wd_count;
        end
        if (we_mean) begin
            mem_mean[wr_addr] <= wd_mean;
        end
        r_stamp_q <= mem_stamp[rd_addr];
        r_count_q <= mem_count[rd_addr];
        r_mean_q  <= mem_mean[rd_addr];
    end

    // Control state, slot status and written-since-reset marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_vstamp    <= '0;
            r_vcount    <= '0;
            r_vmean     <= '0;
            r_vs_q      <= 1'b0;
            r_vc_q      <= 1'b0;
            r_vm_q      <= 1'b0;
            r_pause     <= '0;
            r_tick      <= '0;
            r_last      <= SW'(SLOTS - 1);
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_status[i] <= STAT_IDLE;
            end
        end else begin
            r_state <= n_state;
            r_vs_q  <= r_vstamp[rd_addr];
            r_vc_q  <= r_vcount[rd_addr];
            r_vm_q  <= r_vmean[rd_addr];
            if (we_stamp) begin
                r_vstamp[wr_addr] <= 1'b1;
            end
            if (we_count) begin
                r_vcount[wr_addr] <= 1'b1;
            end
            if (we_mean) begin
                r_vmean[wr_addr] <= 1'b1;
            end
            case (r_state)
                BK_IDLE: begin
                    if (i_item_valid) begin
                        case (i_item.op)
                            OP_READY:   r_status[slot_idx] <= STAT_READY;
                            OP_UNREADY: r_status[slot_idx] <= STAT_IDLE;
                            OP_CLEAR:   r_status[slot_idx] <= STAT_IDLE;
                            OP_PAUSE:   r_pause <= i_item.pause_end;
                            default: ;
                        endcase
                    end
                end
                BK_CNT_WR: begin
                    r_status[r_best] <= STAT_RUNNING;
                    r_last           <= r_best;
                    r_tick           <= r_now;
                end
                BK_MEAN_WR: begin
                    if (r_status[r_last] == STAT_RUNNING) begin
                        r_status[r_last] <= STAT_IDLE;
                    end
                end
                default: ;
            endcase
            // Hold the result beat until taken
            if (r_state == BK_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the scan, the mean update and the result
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_now         <= i_item.now;
                r_res.chosen  <= '0;
                r_res.mean    <= '0;
                r_res.outcome <= (i_item.op == OP_DISPATCH && paused) ? OUT_PAUSED : OUT_OK;
                r_k           <= '0;
                r_cand_v      <= 1'b0;
                r_found       <= 1'b0;
                r_div_cnt     <= '0;
                if (is_rr && (r_last != SW'(SLOTS - 1))) begin
                    r_base <= r_last + SW'(1);
                end else begin
                    r_base <= '0;
                end
            end
            BK_SCAN: begin
                r_k        <= r_k + KW'(1);
                r_cand_idx <= scan_idx;
                r_cand_ok  <= (r_status[scan_idx] == STAT_READY);
                r_cand_v   <= 1'b1;
            end
            BK_PICK: begin
                r_cand_v <= 1'b0;
            end
            BK_DECIDE: begin
                if (!r_found) begin
                    r_res.outcome <= OUT_EMPTY;
                end
            end
            BK_CNT_WR: begin
                r_res.chosen <= 6'(r_best);
            end
            BK_MUL: begin
                r_acc <= prod_old + prod_new;
            end
            BK_DIV: begin
                r_quo     <= quo_n;
                r_div_cnt <= r_div_cnt + 3'd1;
            end
            BK_MEAN_WR: begin
                r_res.chosen <= 6'(r_last);
                r_res.mean   <= r_quo[31:0];
            end
            BK_OUT: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: ;
        endcase
        // Keep the best candidate seen so far
        if ((r_state == BK_SCAN || r_state == BK_PICK) && take) begin
            r_found    <= 1'b1;
            r_best     <= r_cand_idx;
            r_best_key <= cand_key;
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

endmodule

// ===== src/process_table_scheduler_top.sv =====
// Make ready, make not ready, clear, pause and unknown events go from idle to the output state;
// a dispatch scans every slot, one slot per cycle through a single comparator, and writes the
// count of its pick; a refusal while paused skips the scan; a run done takes a multiply, then
// seven shift-and-add steps of the divide by ten. Throughput: one event at a time in the
// executor; a two-beat queue and an output register let input and output stall independently.
// Reset (synchronous, active low) clears slot status, memory valid marks and control at once.
module process_table_scheduler_top
    import pts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // slot[5:0], now[37:6], pause_end[69:38]
    input  logic [2:0]            s_axis_tuser,  // kind[2:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // chosen_slot[5:0], mean_run[37:6]
    output logic [1:0]            m_axis_tuser,  // outcome[1:0]
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [3:0]            i_cfg_data
);

    logic [1:0] r_policy;
    logic [3:0] r_weight;
    t_item      w_item;
    logic       w_item_valid;
    logic       w_pop;
    t_result    w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_RST;
            r_weight <= WEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLICY: r_policy <= i_cfg_data[1:0];
                CFG_WEIGHT: r_weight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pts_front #(.SLOTS(SLOTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tvalid     (s_axis_tvalid),
        .o_tready     (s_axis_tready),
        .i_tdata      (s_axis_tdata),
        .i_tuser      (s_axis_tuser),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_pop        (w_pop)
    );

    pts_back #(.SLOTS(SLOTS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_pop        (w_pop),
        .i_policy     (r_policy),
        .i_weight     (r_weight),
        .o_res        (w_res),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, w_res.mean, w_res.chosen};
    assign m_axis_tuser = w_res.outcome;

endmodule

// ===== verif/process_table_scheduler_checker.sv =====
module process_table_scheduler_checker
    import pts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    input  logic                  i_s_ready,
    input  logic [IN_DATA_W-1:0]  i_s_data,   // slot[5:0], now[37:6], pause_end[69:38]
    input  logic [2:0]            i_s_user,   // kind[2:0]
    input  logic                  i_m_valid,
    input  logic                  i_m_ready,
    input  logic [OUT_DATA_W-1:0] i_m_data,   // chosen_slot[5:0], mean_run[37:6]
    input  logic [1:0]            i_m_user,   // outcome[1:0]
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [3:0]            i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_results_seen,
    output int                    o_dispatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = SLOTS_DEF;

    // Shadow of the task table
    t_status     tbl_status [NSLOT];
    logic [31:0] tbl_stamp  [NSLOT];
    logic [31:0] tbl_count  [NSLOT];
    logic [31:0] tbl_mean   [NSLOT];
    logic [31:0] pause_deadline;
    logic [5:0]  prev_pick;
    logic [31:0] run_start;
    logic [1:0]  cur_policy;
    logic [3:0]  cur_weight;

    t_result expected_results[$];

    assign o_pending = expected_results.size();

    // Choose a ready slot; returns NSLOT when none is ready
    function automatic int choose_slot();
        int best;
        int s;
        best = NSLOT;
        if (cur_policy == POL_FEWEST || cur_policy == POL_OLDEST) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (tbl_status[i] != STAT_READY) continue;
                if (best == NSLOT) best = i;
                else if (cur_policy == POL_FEWEST) begin
                    if (tbl_count[i] < tbl_count[best]) best = i;
                end else if (tbl_stamp[i] < tbl_stamp[best]) best = i;
            end
            return best;
        end
        for (int i = 1; i <= NSLOT; i++) begin
            s = (int'(prev_pick) + i) % NSLOT;
            if (tbl_status[s] == STAT_READY) return s;
        end
        return NSLOT;
    endfunction

    // Apply one event to the shadow table and return its result
    task automatic schedule_event(input logic [2:0] kind, input logic [5:0] slot,
                                  input logic [31:0] now, input logic [31:0] pend,
                                  output t_result res);
        int          s;
        logic [31:0] elapsed;
        logic [63:0] w;
        logic [63:0] len;
        logic [63:0] m;
        res = '0;
        case (kind)
            KIND_READY: begin
                if (tbl_status[slot] == STAT_IDLE) tbl_stamp[slot] = now;
                tbl_status[slot] = STAT_READY;
            end
            KIND_UNREADY: tbl_status[slot] = STAT_IDLE;
            KIND_DISPATCH: begin
                if (now < pause_deadline) res.outcome = OUT_PAUSED;
                else begin
                    s = choose_slot();
                    if (s >= NSLOT) res.outcome = OUT_EMPTY;
                    else begin
                        tbl_status[s] = STAT_RUNNING;
                        if (tbl_count[s] != COUNT_MAX) tbl_count[s] = tbl_count[s] + 1;
                        prev_pick = s[5:0];
                        run_start = now;
                        res.chosen = s[5:0];
                        o_dispatches++;
                    end
                end
            end
            KIND_RUN_DONE: begin
                w = (cur_weight > WEIGHT_MAX) ? 64'(WEIGHT_MAX) : 64'(cur_weight);
                // Elapsed ticks wrap at 32 bits
                elapsed = now - run_start;
                len = 64'(elapsed);
                m = ((64'd10 - w) * 64'(tbl_mean[prev_pick]) + len * w) / 64'd10;
                tbl_mean[prev_pick] = m[31:0];
                if (tbl_status[prev_pick] == STAT_RUNNING) tbl_status[prev_pick] = STAT_IDLE;
                res.chosen = prev_pick;
                res.mean = m[31:0];
            end
            KIND_PAUSE: pause_deadline = pend;
            KIND_CLEAR: begin
                tbl_status[slot] = STAT_IDLE;
                tbl_stamp[slot] = '0;
                tbl_count[slot] = '0;
                tbl_mean[slot] = '0;
            end
            default: ;
        endcase
    endtask

    // Track config writes, predict accepted beats, compare result beats
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_res;
        t_result pred;
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                tbl_status[i] = STAT_IDLE;
                tbl_stamp[i] = '0;
                tbl_count[i] = '0;
                tbl_mean[i] = '0;
            end
            pause_deadline = '0;
            prev_pick = 6'(NSLOT - 1);
            run_start = '0;
            cur_policy = POLICY_RST;
            cur_weight = WEIGHT_RST;
            expected_results.delete();
            o_fail_count = 0;
            o_results_seen = 0;
            o_dispatches = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_POLICY) cur_policy = i_cfg_data[1:0];
                else cur_weight = i_cfg_data;
            end
            if (i_m_valid && i_m_ready) begin
                got.outcome = i_m_user;
                got.chosen = i_m_data[5:0];
                got.mean = i_m_data[37:6];
                o_results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: outcome %0d slot %0d mean %0d",
                           got.outcome, got.chosen, got.mean);
                    o_fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got.outcome !== exp_res.outcome) begin
                        $error("outcome: expected %0d, got %0d", exp_res.outcome, got.outcome);
                        o_fail_count++;
                    end
                    if (got.chosen !== exp_res.chosen) begin
                        $error("chosen_slot: expected %0d, got %0d", exp_res.chosen,
                               got.chosen);
                        o_fail_count++;
                    end
                    if (got.mean !== exp_res.mean) begin
                        $error("mean_run: expected %0d, got %0d", exp_res.mean, got.mean);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_valid && i_s_ready) begin
                schedule_event(i_s_user, i_s_data[5:0], i_s_data[37:6], i_s_data[69:38], pred);
                expected_results.push_back(pred);
            end
        end
    end

endmodule

// ===== verif/process_table_scheduler_top_test.sv =====
module process_table_scheduler_top_test;
    import pts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [2:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [3:0]            i_cfg_data;

    int fail_count;
    int pending;
    int results_seen;
    int dispatches;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int cycles;
    int hold_requests;
    int holds_done;
    logic [31:0] tick;

    process_table_scheduler_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    process_table_scheduler_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_valid      (s_axis_tvalid),
        .i_s_ready      (s_axis_tready),
        .i_s_data       (s_axis_tdata),
        .i_s_user       (s_axis_tuser),
        .i_m_valid      (m_axis_tvalid),
        .i_m_ready      (m_axis_tready),
        .i_m_data       (m_axis_tdata),
        .i_m_user       (m_axis_tuser),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_dispatches   (dispatches)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("process_table_scheduler_top_test NOT OK");
            $finish;
        end
    end

    // Result side: random backpressure plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_done) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_done++;
            end
            m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one event beat and hold it until accepted
    task automatic send_event(input logic [2:0] kind, input logic [5:0] slot,
                              input logic [31:0] now, input logic [31:0] pend);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = kind;
        s_axis_tdata = {2'b00, pend, now, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        items_sent++;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] value);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Random event, biased toward ready/dispatch/run-done kinds and toward slots below slot_span
    task automatic random_event(input int slot_span);
        int          r;
        logic [2:0]  kind;
        logic [5:0]  slot;
        logic [31:0] now;
        logic [31:0] pend;
        r = $urandom_range(99);
        if (r < 34) kind = KIND_READY;
        else if (r < 60) kind = KIND_DISPATCH;
        else if (r < 80) kind = KIND_RUN_DONE;
        else if (r < 87) kind = KIND_UNREADY;
        else if (r < 92) kind = KIND_CLEAR;
        else if (r < 97) kind = KIND_PAUSE;
        else kind = 3'($urandom_range(7, 6));
        slot = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                        : 6'($urandom_range(slot_span - 1));
        tick = tick + $urandom_range(400);
        now = ($urandom_range(19) == 0) ? $urandom() : tick;
        pend = ($urandom_range(3) == 0) ? $urandom() : tick + $urandom_range(600);
        if ($urandom_range(5) == 0) pend = tick - $urandom_range(100);
        send_event(kind, slot, now, pend);
    endtask

    initial begin
        int slot_span;
        logic [1:0] policies [6];
        logic [3:0] weights [6];
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_POLICY;
        i_cfg_data = '0;
        send_idle_pct = 11;
        recv_idle_pct = 47;
        items_sent = 0;
        tick = 32'd1000;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, round robin, stamp keeping, pause, clear, unknown kinds
        send_event(KIND_DISPATCH, 6'd0, 32'd0, 32'd0);
        send_event(KIND_READY, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(KIND_READY, 6'd0, 32'd5, 32'd0);
        send_event(KIND_READY, 6'd0, 32'd9, 32'd0);
        send_event(KIND_DISPATCH, 6'd0, 32'd10, 32'd0);
        send_event(KIND_READY, 6'd0, 32'd20, 32'd0);
        send_event(KIND_RUN_DONE, 6'd0, 32'd110, 32'd0);
        send_event(KIND_RUN_DONE, 6'd0, 32'd4, 32'd0);
        send_event(KIND_DISPATCH, 6'd0, 32'd200, 32'd0);
        send_event(KIND_PAUSE, 6'd0, 32'd0, 32'hFFFF_FFFF);
        send_event(KIND_DISPATCH, 6'd0, 32'hFFFF_FFFE, 32'd0);
        send_event(KIND_DISPATCH, 6'd0, 32'hFFFF_FFFF, 32'd0);
        send_event(KIND_PAUSE, 6'd0, 32'd0, 32'd0);
        send_event(KIND_RUN_DONE, 6'd0, 32'd0, 32'd0);
        send_event(KIND_UNREADY, 6'd0, 32'd0, 32'd0);
        send_event(KIND_CLEAR, 6'd63, 32'd0, 32'd0);
        send_event(3'd6, 6'd1, 32'd0, 32'd0);
        send_event(3'd7, 6'd2, 32'd0, 32'd0);
        send_event(KIND_DISPATCH, 6'd0, 32'd300, 32'd0);

        // Directed: extreme weights and the undefined policy code 3
        write_reg(CFG_WEIGHT, 4'd15);
        write_reg(CFG_POLICY, 4'd3);
        send_event(KIND_READY, 6'd5, 32'd7, 32'd0);
        send_event(KIND_DISPATCH, 6'd0, 32'd8, 32'd0);
        send_event(KIND_RUN_DONE, 6'd0, 32'd7, 32'd0);
        write_reg(CFG_WEIGHT, 4'd0);
        send_event(KIND_RUN_DONE, 6'd0, 32'd100, 32'd0);

        // Random phases across policy and weight settings
        policies = '{POL_RR, POL_FEWEST, POL_OLDEST, 2'd3, POL_FEWEST, POL_OLDEST};
        weights = '{4'd0, 4'd10, 4'd15, 4'd5, 4'd1, 4'($urandom_range(15))};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_POLICY, 4'(policies[ph]));
            write_reg(CFG_WEIGHT, weights[ph]);
            send_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 47 : 0;
            recv_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 11 : 0;
            if (ph == 4) recv_idle_pct = 0;
            slot_span = (ph % 2 == 0) ? 8 : 64;
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
                if (ph == 2 && n == 50) hold_requests++;
                if (ph == 3 && n == 100) wait_drained();
                random_event(slot_span);
            end
        end

        // Drain and give the verdict
        wait_drained();
        repeat (100) @(negedge i_clk);
        $display("sent %0d events, checked %0d results, %0d dispatches",
                 items_sent, results_seen, dispatches);
        $display("covered all policies, weights 0 to 15, pause, clear and backpressure");
        if (fail_count == 0) begin
            $display("process_table_scheduler_top_test OK");
        end else begin
            $display("process_table_scheduler_top_test NOT OK");
        end
        $finish;
    end

endmodule
